// File: hw/rtl/fir_pkg.sv
// Shared types and constants for the 31-tap FIR filter block.
`timescale 1ns / 1ps

package fir_pkg;

    // Fixed field widths of the stream payload.
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 5;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    // Request kinds carried in tuser.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Saturation limits of the 16-bit result.
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic sample_wr;
        logic coef_wr;
        logic mac_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/fir_filter_31_tap.sv
// Top level of the direct-form FIR filter with stream ports.
`timescale 1ns / 1ps
// A sample request runs TAPS MAC steps, then waits in the drain state until the multiply
// pipeline is empty and the output register is free, loads the result and returns to idle;
// the block takes no new request until then.
// A coefficient write is taken in idle and produces no result.
// Reset is synchronous and active low; afterwards a clearing pass zeroes both memories,
// during which s_axis_tready stays low.

module fir_filter_31_tap
    import fir_pkg::*;
#(
    parameter int TAPS           = 31,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0 up: sample_in[15:0], tap_index[20:16], tap_value[36:21], zeros.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0 up: kind (0 = sample, 1 = coefficient write).
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0 up: sample_out[15:0].
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // The controller walks through the taps one per cycle and the datapath
    // holds the delay line and the coefficients in two small memories. The
    // delay line is a circular buffer: a new sample overwrites the oldest
    // entry, so no data moves when a sample arrives. Each MAC step reads one
    // coefficient and one delayed sample, multiplies them in a registered
    // stage and adds the product into a wide accumulator, so the sum is exact.
    //
    // The output sits in its own register, so a finished result can wait for
    // the downstream side while the block already takes the next request.

    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [SAMPLE_W-1:0] w_sample_in;
    logic [INDEX_W-1:0]         w_tap_index;
    logic signed [SAMPLE_W-1:0] w_tap_value;
    logic signed [SAMPLE_W-1:0] w_sample_out;

    // Unpack the request payload.
    assign w_sample_in = s_axis_tdata[15:0];
    assign w_tap_index = s_axis_tdata[20:16];
    assign w_tap_value = s_axis_tdata[36:21];

    fir_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fir_datapath #(
        .TAPS           (TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample_in  (w_sample_in),
        .i_tap_index  (w_tap_index),
        .i_tap_value  (w_tap_value),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_sample_out (w_sample_out)
    );

    assign m_axis_tdata = w_sample_out;

endmodule

// File: hw/rtl/fir_ctrl.sv
// Controller state machine of the FIR filter: clearing, request intake and MAC sequencing.
`timescale 1ns / 1ps

module fir_ctrl
    import fir_pkg::*;
#(
    parameter int TAPS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CW = $clog2(TAPS);
    localparam logic [CW-1:0] LAST_CNT = CW'(TAPS - 1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_accept;
    logic          w_last;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_last   = (r_cnt == LAST_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = w_last ? '0 : r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept && (i_in_kind == KIND_SAMPLE)) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                n_cnt = w_last ? '0 : r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // Outputs decoded from the state. In idle the input is always ready, so a valid
    // request is an accepted one.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.sample_wr = (i_in_kind == KIND_SAMPLE);
                    o_cmd.coef_wr   = (i_in_kind == KIND_COEF);
                end
            end
            ST_MAC: begin
                o_cmd.mac_step = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.out_load = !i_status.pipe_busy && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/fir_datapath.sv
// FIR datapath: sample and coefficient memories, multiply-accumulate pipeline, output register.
`timescale 1ns / 1ps

module fir_datapath
    import fir_pkg::*;
#(
    parameter int TAPS           = 31,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [INDEX_W-1:0]         i_tap_index,
    input  logic signed [SAMPLE_W-1:0] i_tap_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    localparam int AW    = $clog2(TAPS);
    localparam int IW    = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int ACC_W = PROD_W + $clog2(TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

    logic signed [SAMPLE_W-1:0] r_dly_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] r_coef_mem [TAPS];

    logic [AW-1:0]              r_wp;
    logic [AW-1:0]              r_dptr;
    logic [AW-1:0]              r_cptr;
    logic signed [SAMPLE_W-1:0] r_dly_rd;
    logic signed [SAMPLE_W-1:0] r_coef_rd;
    logic                       r_rd_vld;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic [IW-1:0]              w_idx_ext;
    logic                       w_idx_ok;
    logic signed [ACC_W-1:0]    w_shift;
    logic                       w_fits;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_idx_ext = IW'(i_tap_index);
    assign w_idx_ok  = (w_idx_ext < IW'(TAPS));

    // Delay line held as a circular buffer; the newest sample sits just behind the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_dly_mem[r_cptr] <= '0;
        end else if (i_cmd.sample_wr) begin
            r_dly_mem[r_wp] <= i_sample_in;
        end
        r_dly_rd <= r_dly_mem[r_dptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_coef_mem[r_cptr] <= '0;
        end else if (i_cmd.coef_wr && w_idx_ok) begin
            r_coef_mem[AW'(w_idx_ext)] <= i_tap_value;
        end
        r_coef_rd <= r_coef_mem[r_cptr];
    end

    // Address pointers and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_dptr     <= '0;
            r_cptr     <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.mac_step;
            r_prod_vld <= r_rd_vld;
            if (i_cmd.clear_en || i_cmd.mac_step) begin
                r_cptr <= (r_cptr == LAST_ADDR) ? '0 : r_cptr + 1'b1;
            end else if (i_cmd.sample_wr) begin
                r_cptr <= '0;
            end
            if (i_cmd.sample_wr) begin
                r_dptr <= r_wp;
                r_wp   <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
            end else if (i_cmd.mac_step) begin
                r_dptr <= (r_dptr == '0) ? LAST_ADDR : r_dptr - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Product and accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_rd * r_dly_rd;
        if (i_cmd.sample_wr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_sat;
        end
    end

    // Arithmetic shift rounds toward minus infinity; then clamp to 16 bits.
    assign w_shift = r_acc >>> COEF_FRAC_BITS;
    assign w_fits  = (&w_shift[ACC_W-1:SAMPLE_W-1]) || !(|w_shift[ACC_W-1:SAMPLE_W-1]);
    assign w_sat   = w_fits ? w_shift[SAMPLE_W-1:0]
                   : (w_shift[ACC_W-1] ? SAT_MIN : SAT_MAX);

    assign o_status.pipe_busy = r_rd_vld || r_prod_vld;
    assign o_status.out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid        = r_out_vld;
    assign o_sample_out       = r_out_data;

endmodule

// File: hw/rtl/fir_chk.sv
// Port-level assertion checker for the FIR filter, bound to the top level.
`timescale 1ns / 1ps

module fir_chk
    import fir_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [0:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic w_s_accept;

    assign w_s_accept = s_axis_tvalid && s_axis_tready;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The clearing pass keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // A sample request occupies the block for the following cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept && (s_axis_tuser[0] == KIND_SAMPLE) |=> !s_axis_tready)
        else $error("block idle after sample request");

    // A coefficient write leaves the block ready and produces no result.
    a_coef_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept && (s_axis_tuser[0] == KIND_COEF) && !m_axis_tvalid
        |=> s_axis_tready && !m_axis_tvalid)
        else $error("coefficient write produced a result or stalled");

    // A new result appears only as the block returns to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while block busy");

endmodule

bind fir_filter_31_tap fir_chk u_fir_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/fir_output_checker.sv
// Checker that predicts every filtered sample and compares it with the block's output stream.
`timescale 1ns / 1ps

module fir_output_checker
    import fir_pkg::*;
#(
    parameter int TAPS           = 31,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [0:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending,
    output int unsigned          o_checked
);

    logic signed [SAMPLE_W-1:0] history [TAPS];
    logic signed [SAMPLE_W-1:0] coefs [TAPS];
    logic signed [SAMPLE_W-1:0] expected_outputs [$];
    int unsigned                fail_total;
    int unsigned                checked_total;

    // Shifts the new sample into the history and returns the saturated dot product.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint acc;
        longint scaled;
        int     k;
        for (k = TAPS - 1; k > 0; k--) begin
            history[k] = history[k-1];
        end
        history[0] = x;
        acc = 0;
        for (k = 0; k < TAPS; k++) begin
            acc += longint'(coefs[k]) * longint'(history[k]);
        end
        // An arithmetic shift of a signed value rounds toward minus infinity.
        scaled = acc >>> COEF_FRAC_BITS;
        if (scaled > longint'(SAT_MAX)) begin
            scaled = longint'(SAT_MAX);
        end else if (scaled < longint'(SAT_MIN)) begin
            scaled = longint'(SAT_MIN);
        end
        return scaled[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic signed [SAMPLE_W-1:0] want;
        logic signed [SAMPLE_W-1:0] got;
        logic [INDEX_W-1:0]         slot;
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                history[k] = '0;
                coefs[k]   = '0;
            end
            expected_outputs.delete();
            fail_total    = 0;
            checked_total = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == KIND_COEF) begin
                    slot = s_axis_tdata[SAMPLE_W +: INDEX_W];
                    // Writes aimed past the last tap are dropped by the block.
                    if (slot < TAPS) begin
                        coefs[slot] = s_axis_tdata[SAMPLE_W+INDEX_W +: SAMPLE_W];
                    end
                end else begin
                    expected_outputs.push_back(filter_sample(s_axis_tdata[SAMPLE_W-1:0]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected sample_out: expected none, actual %0d (0x%h)",
                             $time, got, got);
                    fail_total++;
                end else begin
                    want = expected_outputs.pop_front();
                    checked_total++;
                    if (got !== want) begin
                        $display("%0t: sample_out mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                                 $time, want, want, got, got);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_pending    <= expected_outputs.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top that drives requests into the FIR filter and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
    import fir_pkg::*;

    localparam int TAPS           = 31;
    localparam int COEF_FRAC_BITS = 15;
    localparam int CLK_HALF_NS    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 1780;
    localparam int HOLDOFF_CYCLES = 400;
    // Ample settling time at the end, twice the span of one sample request.
    localparam int DRAIN_CYCLES   = 2 * (TAPS + 3);
    localparam int LIMIT_CYCLES   = 1000000;

    // How wide the random coefficient and sample values spread.
    typedef enum logic [1:0] {
        LVL_QUIET,
        LVL_FULL,
        LVL_EXTREME
    } t_level;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0 up: sample_in[15:0], tap_index[20:16], tap_value[36:21], zeros.
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // Fields from bit 0 up: kind (0 = sample, 1 = coefficient write).
    logic [0:0]           s_axis_tuser  = KIND_SAMPLE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0 up: sample_out[15:0].
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // Set by the stimulus to ask the receiver for one long hold-off.
    logic        holdoff_armed = 1'b0;
    int unsigned burst_left    = 0;
    int unsigned sample_count  = 0;
    int unsigned coef_count    = 0;
    int unsigned stray_count   = 0;
    int unsigned item_count    = 0;

    // The clock idles low and rises first after half a period.
    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    fir_filter_31_tap #(
        .TAPS          (TAPS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    fir_output_checker #(
        .TAPS          (TAPS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Draws a 16-bit value. Quiet values keep the sums mostly inside the output range,
    // full-range values tend to saturate, and extreme values hit the corners of the range.
    function automatic logic [15:0] pick_level(input t_level lvl);
        logic [15:0] v;
        if (lvl == LVL_QUIET && $urandom_range(15) == 0) begin
            lvl = LVL_FULL;
        end
        case (lvl)
            LVL_QUIET: begin
                v = 16'(int'($urandom_range(0, 1023)) - 512);
            end
            LVL_EXTREME: begin
                case ($urandom_range(4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'hFFFF;
                    3: v = 16'h0000;
                    default: v = 16'h0001;
                endcase
            end
            default: begin
                v = 16'($urandom);
            end
        endcase
        return v;
    endfunction

    // Offers one request and waits for the edge where it is accepted. The sender works in
    // bursts: when a burst runs out, valid drops for a gap before the task returns, so that
    // valid is never lowered and raised again in the same time step.
    task automatic send_request(
        input logic        kind,
        input logic [15:0] sample,
        input logic [4:0]  index,
        input logic [15:0] value
    );
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, value, index, sample};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_COEF) begin
            coef_count++;
            if (index < TAPS) begin
                item_count++;
            end else begin
                stray_count++;
            end
        end else begin
            sample_count++;
            item_count++;
        end
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(8, 40)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            // Long bursts give stretches where the sender never idles.
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(64, 200)
                                                   : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // The receiver stalls on its own pattern: phases of random length with a random stall
    // rate, including phases with no stalls at all. When the stimulus arms a hold-off, the
    // receiver keeps ready low for a long stretch so that the block fills up and stalls
    // its input while the sender keeps offering requests.
    initial begin : receiver
        int unsigned stall_pct;
        int unsigned pattern_left;
        int unsigned holdoff_left;
        stall_pct    = 0;
        pattern_left = 0;
        holdoff_left = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_armed) begin
                holdoff_armed = 1'b0;
                holdoff_left  = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    pattern_left = $urandom_range(20, 300);
                end
                pattern_left--;
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Stimulus: reset, a short directed part, then random coefficient sets each followed
    // by a stream of samples.
    initial begin : stimulus
        int unsigned n_writes;
        int unsigned n_samples;
        logic        full_reload;
        logic [4:0]  slot;
        t_level      coef_lvl;
        t_level      sample_lvl;
        logic        holdoff_done;
        logic        drain_done;

        holdoff_done = 1'b0;
        drain_done   = 1'b0;
        burst_left   = $urandom_range(1, 16);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With all coefficients still zero, both extreme samples must give zero.
        send_request(KIND_SAMPLE, 16'h7FFF, 5'd3, 16'h1234);
        send_request(KIND_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        // The most negative coefficient times the most negative sample overflows upward.
        send_request(KIND_COEF, 16'h0000, 5'd0, 16'h8000);
        // A write aimed one past the last tap must be ignored.
        send_request(KIND_COEF, 16'hFFFF, 5'(TAPS), 16'h5555);
        send_request(KIND_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(KIND_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        // Large positive coefficients on the first taps and the last tap: a run of
        // positive full-scale samples saturates high, a run of negative ones saturates low.
        send_request(KIND_COEF, 16'h0000, 5'(TAPS - 1), 16'h7FFF);
        send_request(KIND_COEF, 16'h0000, 5'd0, 16'h7FFF);
        send_request(KIND_COEF, 16'h0000, 5'd1, 16'h7FFF);
        send_request(KIND_SAMPLE, 16'h7FFF, 5'd31, 16'hFFFF);
        send_request(KIND_SAMPLE, 16'h7FFF, 5'd31, 16'hFFFF);
        send_request(KIND_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(KIND_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        // The smallest coefficient step, then a negative sample that rounds toward minus one.
        send_request(KIND_COEF, 16'h0000, 5'd0, 16'h0001);
        send_request(KIND_COEF, 16'h0000, 5'd1, 16'h0000);
        send_request(KIND_SAMPLE, 16'hFFFF, 5'd0, 16'h0000);
        send_request(KIND_SAMPLE, 16'h0000, 5'd0, 16'h0000);
        send_request(KIND_SAMPLE, 16'h0001, 5'd0, 16'h0000);

        while (item_count < RANDOM_ITEMS) begin
            // A new coefficient set: either a full reload or a few scattered writes, where
            // the top index value lands past the last tap and is ignored by the block.
            full_reload = ($urandom_range(3) == 0);
            n_writes    = full_reload ? TAPS : $urandom_range(1, 8);
            coef_lvl    = t_level'($urandom_range(2));
            for (int w = 0; w < n_writes; w++) begin
                slot = full_reload ? 5'(w) : 5'($urandom_range(31));
                send_request(KIND_COEF, 16'($urandom), slot, pick_level(coef_lvl));
            end

            n_samples  = $urandom_range(10, 60);
            sample_lvl = t_level'($urandom_range(2));
            for (int s = 0; s < n_samples; s++) begin
                send_request(KIND_SAMPLE, pick_level(sample_lvl), 5'($urandom),
                             16'($urandom));
            end

            // Once, let the output stall for a long time while requests keep coming; the
            // sender does not pause right after arming it, so the block really fills up.
            // Otherwise, once and now and then after that, pause until every result is out.
            if (!holdoff_done && item_count > RANDOM_ITEMS / 3) begin
                holdoff_armed = 1'b1;
                holdoff_done  = 1'b1;
            end else if ((!drain_done && item_count > (2 * RANDOM_ITEMS) / 3)
                    || $urandom_range(15) == 0) begin
                drain_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
        end

        // All requests are in: wait for the last results, then let the block settle.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d sample requests and %0d coefficient writes (%0d past the last tap).",
                 sample_count, coef_count, stray_count);
        $display("Checked %0d filtered outputs across quiet, full-scale and saturating levels.",
                 checked);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: a correct run finishes in a small fraction of this time.
    initial begin : watchdog
        #(longint'(LIMIT_CYCLES) * 2 * CLK_HALF_NS);
        $display("Timeout with %0d results still outstanding.", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
